// File: design/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants of the text console scrollback engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

    // Cell memory geometry
    localparam int ADDR_W     = 14;
    localparam int CELL_COUNT = 16384;
    localparam int DATA_W     = 16;
    localparam int MAX_CONS   = 4;
    localparam int COL_W      = 8;      // holds the widest screen row

    // Parameter defaults
    localparam int VIDEO_MEM_BYTES_DEF = 32768;
    localparam int NUM_CONSOLES_DEF    = 3;
    localparam int SCREEN_WIDTH_DEF    = 80;
    localparam int SCREEN_CELLS_DEF    = 2000;

    // Character codes
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] COLOR_RESET  = 8'd7;

    // Request codes
    localparam logic [2:0] REQ_PUT    = 3'd0;
    localparam logic [2:0] REQ_UP     = 3'd1;
    localparam logic [2:0] REQ_DOWN   = 3'd2;
    localparam logic [2:0] REQ_SELECT = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  console_sel;
        logic [7:0]  char_code;
        logic [13:0] cell_index;
    } t_in;

    typedef struct packed {
        logic [13:0] shown_cursor;
        logic [13:0] shown_start;
        logic [15:0] cell_data;
    } t_out;

    // One access to the cell memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_req;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_DIVW,
        ST_MUL,
        ST_PUT,
        ST_OVF,
        ST_CP_RD,
        ST_CP_WR,
        ST_ROW,
        ST_VIS,
        ST_SCROLL,
        ST_VIS_NEXT,
        ST_RD,
        ST_RD_WAIT,
        ST_FIN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: design/tcs_div.sv
// ----------------------------------------------------------------------------
// tcs_div
// Divider by the screen width through a reciprocal multiply, with a registered quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_div #(
    parameter int SCREEN_WIDTH = tcs_pkg::SCREEN_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [tcs_pkg::ADDR_W-1:0] i_dividend,
    output logic                           o_done,
    output logic [tcs_pkg::ADDR_W-1:0]     o_quotient
);

    // Rounded-up reciprocal; the error stays under 1/SCREEN_WIDTH for every
    // 14-bit dividend as long as the width is 16 to 256
    localparam int SHIFT   = 22;
    localparam int RECIP_W = 19;
    localparam int PROD_W  = tcs_pkg::ADDR_W + RECIP_W;
    localparam int QUO_W   = PROD_W - SHIFT;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << SHIFT) / SCREEN_WIDTH + 1);

    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  r_q;
    logic              r_done;

    // Multiply by the reciprocal
    assign prod = PROD_W'(i_dividend) * PROD_W'(RECIP);

    // Control: pulse done in the cycle after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // Datapath: keep the quotient bits of the product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= prod[PROD_W-1:SHIFT];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = tcs_pkg::ADDR_W'(r_q);

endmodule

`default_nettype wire

// File: design/tcs_cell_mem.sv
// ----------------------------------------------------------------------------
// tcs_cell_mem
// Single-port video cell memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_cell_mem (
    input  wire logic                       i_clk,
    input  wire tcs_pkg::t_mem_req          i_req,
    output logic [tcs_pkg::DATA_W-1:0]      o_rdata
);

    logic [tcs_pkg::DATA_W-1:0] r_mem [tcs_pkg::CELL_COUNT];
    logic [tcs_pkg::DATA_W-1:0] r_rdata;

    // Write or read one cell
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/text_console_scrollback.sv
// ----------------------------------------------------------------------------
// text_console_scrollback
// Multi-console text engine over a shared 16K-cell video memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole cell memory to zero, one cell per
// cycle, and takes no request meanwhile; color writes are taken at any
// time. Requests are then handled one at a time by a sequencer around a
// reciprocal-multiply divider and a single-port cell memory. Select and
// other no-op requests go from dispatch to the finish; a read cell reads the
// memory first. Scroll up/down takes dispatch, a division of the cursor
// offset by the row width, the row-start multiply, the scroll step and the
// finish. A put char runs the division and multiply, its character step
// and, for each view scroll needed to keep the cursor visible, a row clear
// of SCREEN_WIDTH cells. A region overflow adds a copy of SCREEN_CELLS -
// SCREEN_WIDTH cells (two memory accesses per cell) plus a row clear of
// SCREEN_WIDTH cells. A new request is taken while the last result still
// waits at the output; that request then holds at its finish until the
// waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_scrollback #(
    parameter int VIDEO_MEM_BYTES = tcs_pkg::VIDEO_MEM_BYTES_DEF,
    parameter int NUM_CONSOLES    = tcs_pkg::NUM_CONSOLES_DEF,
    parameter int SCREEN_WIDTH    = tcs_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_CELLS    = tcs_pkg::SCREEN_CELLS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tcs_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output tcs_pkg::t_out      o_out,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [7:0]    i_cfg_data
);

    localparam int AW        = tcs_pkg::ADDR_W;
    localparam int SHARE     = (VIDEO_MEM_BYTES / 2) / NUM_CONSOLES;
    localparam int SIZE      = SHARE / SCREEN_WIDTH * SCREEN_WIDTH;
    localparam int ROWS      = SIZE / SCREEN_WIDTH;
    localparam int GUARD_MAX = ROWS + 1;
    localparam int GUARD_W   = $clog2(GUARD_MAX + 1);
    localparam int COPY_LEN  = SCREEN_CELLS - SCREEN_WIDTH;
    localparam int COPY_OFF  = SIZE + SCREEN_WIDTH - SCREEN_CELLS;
    localparam int CNT_W     = $clog2(SCREEN_CELLS + 1);

    localparam logic [AW-1:0]    COPY_OFF_A = AW'(COPY_OFF);
    localparam logic [AW-1:0]    REFILL_OFF = AW'(SCREEN_CELLS - SCREEN_WIDTH);
    localparam logic [CNT_W-1:0] COPY_LAST  = CNT_W'(COPY_LEN - 1);
    localparam logic [CNT_W-1:0] ROW_LAST   = CNT_W'(SCREEN_WIDTH - 1);
    localparam logic [AW:0]      SIZE_U     = (AW + 1)'(SIZE);
    localparam logic [AW:0]      W_U        = (AW + 1)'(SCREEN_WIDTH);

    localparam logic signed [17:0] SZ_S    = 18'(SIZE);
    localparam logic signed [17:0] W_S     = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] CELLS_S = 18'(SCREEN_CELLS);

    // Zero-extend a cell address into the signed work width
    function automatic logic signed [17:0] sx(input logic [AW-1:0] v);
        return $signed({4'b0000, v});
    endfunction

    tcs_pkg::t_state r_state;
    tcs_pkg::t_state n_state;

    tcs_pkg::t_in    r_in;
    logic [7:0]      r_color;
    logic [AW-1:0]   r_cursor [tcs_pkg::MAX_CONS];
    logic [AW-1:0]   r_start  [tcs_pkg::MAX_CONS];
    logic            r_wrap   [tcs_pkg::MAX_CONS];
    logic [1:0]      r_curcon;
    logic [AW-1:0]   r_shown_cur;
    logic [AW-1:0]   r_shown_st;

    logic [AW:0]     r_cur;
    logic [AW-1:0]   r_st;
    logic            r_full;
    logic [AW-1:0]   r_org;
    logic [AW-1:0]   r_newest;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_before;
    logic [CNT_W-1:0] r_cnt;
    logic [GUARD_W-1:0] r_guard;
    logic            r_from_vis;
    tcs_pkg::t_state r_ret;
    logic [15:0]     r_data;
    logic            r_out_valid;
    tcs_pkg::t_out   r_out;

    tcs_pkg::t_mem_req mem_req;
    logic [15:0]     mem_rdata;
    logic            div_start;
    logic            div_done;
    logic [AW-1:0]   div_q;

    logic            sel_ok;
    logic            is_put;
    logic            is_scroll;
    logic            go_up;
    logic            vis_need;
    logic            overflow;
    logic [AW:0]     cur_off;
    logic [15:0]     blank;
    logic [AW-1:0]   st_next;
    logic            in_fire;

    assign sel_ok    = 32'(r_in.console_sel) < NUM_CONSOLES;
    assign is_put    = r_in.req_type == tcs_pkg::REQ_PUT;
    assign is_scroll = (r_in.req_type == tcs_pkg::REQ_UP)
                    || (r_in.req_type == tcs_pkg::REQ_DOWN);
    assign go_up     = r_from_vis || (r_in.req_type == tcs_pkg::REQ_UP);
    assign blank     = {r_color, tcs_pkg::CH_SPACE};
    assign cur_off   = r_cur - {1'b0, r_org};
    assign overflow  = cur_off >= SIZE_U;
    assign in_fire   = i_in_valid && o_in_ready;

    assign o_in_ready  = r_state == tcs_pkg::ST_IDLE;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Cursor outside the shown window
    always_comb begin
        logic [15:0] cp;
        logic [15:0] sp;
        cp       = {2'b00, r_cur[AW-1:0]};
        sp       = {2'b00, r_st};
        vis_need = (cp >= sp + 16'(SCREEN_CELLS)) || (cp < sp);
    end

    // Wrap-aware view scroll
    always_comb begin
        logic signed [17:0] org;
        logic signed [17:0] cur;
        logic signed [17:0] st;
        logic signed [17:0] newest;
        logic signed [17:0] top;
        logic signed [17:0] oldest;
        logic signed [17:0] nxt;
        org    = sx(r_org);
        cur    = sx(r_cur[AW-1:0]);
        st     = sx(r_st);
        newest = sx(r_newest);
        top    = st - org;
        oldest = '0;
        if (r_full) begin
            oldest = newest + W_S;
            if (oldest >= SZ_S) begin
                oldest = oldest - SZ_S;
            end
        end
        nxt = st;
        if (!go_up) begin
            if (!r_full && top > 0) begin
                nxt = st - W_S;
            end else if (r_full && top != oldest) begin
                if (cur - org >= SZ_S - CELLS_S) begin
                    if (st != org) begin
                        nxt = st - W_S;
                    end
                end else if (st == org) begin
                    nxt = org + SZ_S - CELLS_S;
                end else begin
                    nxt = st - W_S;
                end
            end
        end else begin
            if (!r_full && newest >= top + CELLS_S) begin
                nxt = st + W_S;
            end else if (r_full && top + CELLS_S - W_S != newest) begin
                if (top + CELLS_S == SZ_S) begin
                    nxt = org;
                end else begin
                    nxt = st + W_S;
                end
            end
        end
        st_next = nxt[AW-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcs_pkg::ST_INIT: begin
                if (&r_addr) begin
                    n_state = tcs_pkg::ST_IDLE;
                end
            end
            tcs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tcs_pkg::ST_DISPATCH;
                end
            end
            tcs_pkg::ST_DISPATCH: begin
                priority if (sel_ok && (is_put || is_scroll)) begin
                    n_state = tcs_pkg::ST_DIV;
                end else if (r_in.req_type == tcs_pkg::REQ_READ) begin
                    n_state = tcs_pkg::ST_RD;
                end else begin
                    n_state = tcs_pkg::ST_FIN;
                end
            end
            tcs_pkg::ST_DIV:  n_state = tcs_pkg::ST_DIVW;
            tcs_pkg::ST_DIVW: begin
                if (div_done) begin
                    n_state = tcs_pkg::ST_MUL;
                end
            end
            tcs_pkg::ST_MUL: begin
                if (is_put && !r_from_vis) begin
                    n_state = tcs_pkg::ST_PUT;
                end else begin
                    n_state = tcs_pkg::ST_SCROLL;
                end
            end
            tcs_pkg::ST_PUT: n_state = tcs_pkg::ST_OVF;
            tcs_pkg::ST_OVF: begin
                if (overflow) begin
                    n_state = tcs_pkg::ST_CP_RD;
                end else begin
                    n_state = tcs_pkg::ST_VIS;
                end
            end
            tcs_pkg::ST_CP_RD: n_state = tcs_pkg::ST_CP_WR;
            tcs_pkg::ST_CP_WR: begin
                if (r_cnt == COPY_LAST) begin
                    n_state = tcs_pkg::ST_ROW;
                end else begin
                    n_state = tcs_pkg::ST_CP_RD;
                end
            end
            tcs_pkg::ST_ROW: begin
                if (r_cnt == ROW_LAST) begin
                    n_state = r_ret;
                end
            end
            tcs_pkg::ST_VIS: begin
                if (r_guard != '0 && vis_need) begin
                    n_state = tcs_pkg::ST_DIV;
                end else begin
                    n_state = tcs_pkg::ST_FIN;
                end
            end
            tcs_pkg::ST_SCROLL: begin
                if (r_from_vis) begin
                    n_state = tcs_pkg::ST_ROW;
                end else begin
                    n_state = tcs_pkg::ST_FIN;
                end
            end
            tcs_pkg::ST_VIS_NEXT: begin
                if (r_st == r_before) begin
                    n_state = tcs_pkg::ST_FIN;
                end else begin
                    n_state = tcs_pkg::ST_VIS;
                end
            end
            tcs_pkg::ST_RD:      n_state = tcs_pkg::ST_RD_WAIT;
            tcs_pkg::ST_RD_WAIT: n_state = tcs_pkg::ST_FIN;
            tcs_pkg::ST_FIN:     n_state = tcs_pkg::ST_DONE;
            tcs_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = tcs_pkg::ST_IDLE;
                end
            end
            default: n_state = tcs_pkg::ST_INIT;
        endcase
    end

    // Memory access and divider start per state
    always_comb begin
        mem_req   = '{we: 1'b0, addr: '0, wdata: '0};
        div_start = r_state == tcs_pkg::ST_DIV;
        unique case (r_state)
            tcs_pkg::ST_INIT: begin
                mem_req = '{we: 1'b1, addr: r_addr, wdata: '0};
            end
            tcs_pkg::ST_PUT: begin
                priority if (r_in.char_code == tcs_pkg::CH_NEWLINE) begin
                    mem_req.we = 1'b0;
                end else if (r_in.char_code == tcs_pkg::CH_BACKSPACE) begin
                    mem_req.we    = r_cur > {1'b0, r_org};
                    mem_req.addr  = AW'(r_cur - 1'b1);
                    mem_req.wdata = blank;
                end else begin
                    mem_req.we    = 1'b1;
                    mem_req.addr  = r_cur[AW-1:0];
                    mem_req.wdata = {r_color, r_in.char_code};
                end
            end
            tcs_pkg::ST_CP_RD: begin
                mem_req.addr = r_org + COPY_OFF_A + AW'(r_cnt);
            end
            tcs_pkg::ST_CP_WR: begin
                mem_req = '{we: 1'b1, addr: r_org + AW'(r_cnt), wdata: mem_rdata};
            end
            tcs_pkg::ST_ROW: begin
                mem_req = '{we: 1'b1, addr: r_addr, wdata: blank};
            end
            tcs_pkg::ST_RD: begin
                mem_req.addr = r_in.cell_index;
            end
            default: begin
                mem_req.we = 1'b0;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcs_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Color register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= tcs_pkg::COLOR_RESET;
        end else if (i_cfg_valid) begin
            r_color <= i_cfg_data;
        end
    end

    // Console state, shown registers, sweep address, loop control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < tcs_pkg::MAX_CONS; c++) begin
                r_cursor[c] <= (c < NUM_CONSOLES) ? AW'(c * SHARE) : '0;
                r_start[c]  <= (c < NUM_CONSOLES) ? AW'(c * SHARE) : '0;
                r_wrap[c]   <= 1'b0;
            end
            r_curcon    <= 2'd0;
            r_shown_cur <= '0;
            r_shown_st  <= '0;
            r_addr      <= '0;
            r_guard     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise the result as the item leaves, drop it on transfer
            priority if (r_state == tcs_pkg::ST_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                tcs_pkg::ST_INIT: begin
                    r_addr <= r_addr + 1'b1;
                end
                tcs_pkg::ST_DISPATCH: begin
                    if (sel_ok && r_in.req_type == tcs_pkg::REQ_SELECT) begin
                        r_curcon <= r_in.console_sel;
                    end
                end
                tcs_pkg::ST_OVF: begin
                    r_guard <= GUARD_W'(GUARD_MAX);
                end
                tcs_pkg::ST_CP_WR: begin
                    if (r_cnt == COPY_LAST) begin
                        r_addr <= r_org + REFILL_OFF;
                    end
                end
                tcs_pkg::ST_ROW: begin
                    r_addr <= r_addr + 1'b1;
                end
                tcs_pkg::ST_VIS: begin
                    r_addr <= r_cur[AW-1:0];
                end
                tcs_pkg::ST_VIS_NEXT: begin
                    r_guard <= r_guard - 1'b1;
                end
                tcs_pkg::ST_FIN: begin
                    if (sel_ok && (is_put || is_scroll)) begin
                        r_cursor[r_in.console_sel] <= r_cur[AW-1:0];
                        r_start[r_in.console_sel]  <= r_st;
                        r_wrap[r_in.console_sel]   <= r_full;
                    end
                    if (sel_ok && r_in.console_sel == r_curcon
                        && (is_put || is_scroll
                            || r_in.req_type == tcs_pkg::REQ_SELECT)) begin
                        r_shown_cur <= r_cur[AW-1:0];
                        r_shown_st  <= r_st;
                    end
                end
                default: begin
                    r_guard <= r_guard;
                end
            endcase
        end
    end

    // Working copies of the addressed console and per-item payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in;
        end
        unique case (r_state)
            tcs_pkg::ST_DISPATCH: begin
                r_cur      <= {1'b0, r_cursor[r_in.console_sel]};
                r_st       <= r_start[r_in.console_sel];
                r_full     <= r_wrap[r_in.console_sel];
                r_org      <= AW'(32'(r_in.console_sel) * SHARE);
                r_data     <= '0;
                r_from_vis <= 1'b0;
            end
            tcs_pkg::ST_MUL: begin
                r_newest <= AW'(32'(div_q) * SCREEN_WIDTH);
            end
            tcs_pkg::ST_PUT: begin
                priority if (r_in.char_code == tcs_pkg::CH_NEWLINE) begin
                    r_cur <= {1'b0, r_org} + {1'b0, r_newest} + W_U;
                end else if (r_in.char_code == tcs_pkg::CH_BACKSPACE) begin
                    if (r_cur > {1'b0, r_org}) begin
                        r_cur <= r_cur - 1'b1;
                    end
                end else begin
                    r_cur <= r_cur + 1'b1;
                end
            end
            tcs_pkg::ST_OVF: begin
                r_cnt <= '0;
            end
            tcs_pkg::ST_CP_WR: begin
                if (r_cnt == COPY_LAST) begin
                    r_cnt  <= '0;
                    r_st   <= r_org;
                    r_cur  <= {1'b0, r_org + REFILL_OFF};
                    r_full <= 1'b1;
                    r_ret  <= tcs_pkg::ST_VIS;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            tcs_pkg::ST_ROW: begin
                r_cnt <= r_cnt + 1'b1;
            end
            tcs_pkg::ST_VIS: begin
                r_before   <= r_st;
                r_from_vis <= 1'b1;
            end
            tcs_pkg::ST_SCROLL: begin
                r_st  <= st_next;
                r_cnt <= '0;
                r_ret <= tcs_pkg::ST_VIS_NEXT;
            end
            tcs_pkg::ST_RD_WAIT: begin
                r_data <= mem_rdata;
            end
            tcs_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out <= '{shown_cursor: r_shown_cur,
                               shown_start: r_shown_st,
                               cell_data: r_data};
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    tcs_div #(
        .SCREEN_WIDTH(SCREEN_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (AW'(cur_off)),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    tcs_cell_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Take one transfer, then stay busy until the item is through
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("ready held after accepting a request");

    // Visibility loop never runs past its bound
    a_guard_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_guard <= GUARD_W'(GUARD_MAX))
        else $error("scroll guard out of range");

    // No cell write while waiting for a request
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcs_pkg::ST_IDLE) |-> !mem_req.we)
        else $error("cell write while idle");

    // Shown registers change only when an item finishes
    a_shown_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tcs_pkg::ST_FIN) |=> ($stable(r_shown_cur) && $stable(r_shown_st)))
        else $error("shown registers changed mid-item");

endmodule

`default_nettype wire
